/* hw/rtl/mtap_pkg.sv */
// ----------------------------------------------------------------------------
// mtap_pkg: shared types and constants
// Field widths, register indexes and the item record that links the front
// and back parts of the microring thermal plant.
// ----------------------------------------------------------------------------
package mtap_pkg;

  localparam int DAC_BITS       = 12;
  localparam int TEMP_FRAC_BITS = 16;
  localparam int TEMP_W         = 28;
  localparam int DET_W          = 29;
  localparam int CODE_W         = 16;
  localparam int CFG_IDX_W      = 3;

  // Thermal divider: magnitude times 256 plus half tau.
  localparam int TNUM_W  = TEMP_W + 9;
  localparam int TQ_W    = DET_W;
  // Lorentzian divider remainder and quotient.
  localparam int LREM_W  = 61;
  localparam int TRANS_W = 17;
  localparam int PROD_W  = CODE_W + TRANS_W;
  localparam int ADCV_W  = 38;

  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEWIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAU       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_EN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LASER_EN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_TOP   = 3'd6;

  typedef struct packed {
    logic [DAC_BITS-1:0]      heater_code;
    logic signed [CODE_W-1:0] noise;       // already gated by noise enable
  } item_t;

  typedef enum logic [1:0] {
    SG_ZERO,
    SG_POS,
    SG_NEG
  } sign_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIV,
    ST_UPD,
    ST_DET,
    ST_SQR,
    ST_DEN,
    ST_LDIV,
    ST_ADCM,
    ST_FIN
  } back_state_t;

endpackage

/* hw/rtl/mtap_front.sv */
// ----------------------------------------------------------------------------
// mtap_front: input stage
// Takes input beats, gates the noise sample and holds the item until the
// queue takes it.
// ----------------------------------------------------------------------------
module mtap_front
  import mtap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DAC_BITS-1:0]      in_heater_code,
  input  logic signed [CODE_W-1:0] in_noise_sample,
  input  logic                     noise_en,
  output logic                     push_valid,
  input  logic                     push_ready,
  output item_t                    push_item
);

  logic  stg_v_r, stg_v_nxt;
  item_t stg_r;

  assign in_ready   = !stg_v_r || push_ready;
  assign push_valid = stg_v_r;
  assign push_item  = stg_r;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (push_ready) stg_v_nxt = 1'b0;
    if (in_valid && in_ready) stg_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r.heater_code <= in_heater_code;
      stg_r.noise       <= noise_en ? in_noise_sample : '0;
    end
  end

endmodule

/* hw/rtl/mtap_fifo.sv */
// ----------------------------------------------------------------------------
// mtap_fifo: item queue
// A short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module mtap_fifo
  import mtap_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_pop,
  output item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_item;
  end

endmodule

/* hw/rtl/mtap_back.sv */
// ----------------------------------------------------------------------------
// mtap_back: plant step sequencer
// Runs the thermal lag divider, the Lorentzian divider when the laser is on,
// the ADC model and the crossing latch for one item at a time; holds the result.
// ----------------------------------------------------------------------------
module mtap_back
  import mtap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  item_t                    q_item,
  input  logic [CODE_W-1:0]        resonance,
  input  logic [CODE_W-1:0]        linewidth,
  input  logic [CODE_W-1:0]        tau,
  input  logic [CODE_W-1:0]        peak,
  input  logic                     laser_en,
  input  logic [CODE_W-1:0]        adc_top,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CODE_W-1:0]        out_adc_sample,
  output logic signed [DET_W-1:0]  out_detuning,
  output logic [TEMP_W-1:0]        out_temperature,
  output logic                     out_crossed,
  output logic                     out_clipped
);

  back_state_t state_r, state_nxt;

  logic [TEMP_W-1:0]        temp_r, temp_nxt;
  sign_t                    last_r, last_nxt;
  logic                     unarmed_r, unarmed_nxt;
  logic [5:0]               cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;
  logic [TNUM_W-1:0]        num_r, num_nxt;
  logic [CODE_W:0]          trem_r, trem_nxt;
  logic [TQ_W-1:0]          tq_r, tq_nxt;
  logic signed [CODE_W-1:0] noise_r, noise_nxt;
  logic signed [DET_W-1:0]  d_r, d_nxt;
  logic [DET_W-1:0]         dmag_r, dmag_nxt;
  logic [2*CODE_W-1:0]      fw2_r, fw2_nxt;
  logic [2*DET_W-1:0]       d2_r, d2_nxt;
  logic [LREM_W-1:0]        den_r, den_nxt, lrem_r, lrem_nxt;
  logic [TRANS_W-1:0]       trans_r, trans_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic                     ov_r, ov_nxt;
  logic [CODE_W-1:0]        adc_r, adc_nxt;
  logic signed [DET_W-1:0]  odet_r, odet_nxt;
  logic [TEMP_W-1:0]        otemp_r, otemp_nxt;
  logic                     cross_r, cross_nxt, clip_r, clip_nxt;

  // Datapath temporaries.
  logic signed [DET_W-1:0]  diff;
  logic [DET_W-1:0]         dmag_abs;
  logic [CODE_W+1:0]        trem_sh;
  logic                     tge, lge;
  logic [DET_W-1:0]         temp_sum;
  logic signed [ADCV_W-1:0] v, top_lim;
  logic                     fin_go;
  sign_t                    s_now;

  assign q_pop           = (state_r == ST_IDLE) && q_valid;
  assign out_valid       = ov_r;
  assign out_adc_sample  = adc_r;
  assign out_detuning    = odet_r;
  assign out_temperature = otemp_r;
  assign out_crossed     = cross_r;
  assign out_clipped     = clip_r;
  assign fin_go          = !ov_r || out_ready;

  assign diff     = $signed({1'b0, q_item.heater_code, TEMP_FRAC_BITS'(0)})
                    - $signed({1'b0, temp_r});
  assign trem_sh  = {trem_r, num_r[TNUM_W-1]};
  assign tge      = trem_sh >= {2'b00, tau};
  assign temp_sum = neg_r ? ({1'b0, temp_r} - tq_r) : ({1'b0, temp_r} + tq_r);
  assign dmag_abs = d_r[DET_W-1] ? DET_W'(-d_r) : DET_W'(d_r);
  assign lge      = lrem_r >= den_r;
  assign v        = $signed({{(ADCV_W-PROD_W){1'b0}}, prod_r})
                    + $signed({{(ADCV_W-CODE_W-16){noise_r[CODE_W-1]}}, noise_r, 16'h0000});
  assign top_lim  = $signed({{(ADCV_W-CODE_W-20){1'b0}}, adc_top, 20'h80000});
  assign s_now    = (d_r == '0) ? SG_ZERO : (d_r[DET_W-1] ? SG_NEG : SG_POS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_TDIV;
      ST_TDIV: if (cnt_r == 6'(TNUM_W - 1)) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DET;
      ST_DET:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_DEN;
      ST_DEN:  state_nxt = laser_en ? ST_LDIV : ST_ADCM;
      ST_LDIV: if (cnt_r == 6'(TRANS_W)) state_nxt = ST_ADCM;
      ST_ADCM: state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    temp_nxt    = temp_r;
    last_nxt    = last_r;
    unarmed_nxt = unarmed_r;
    cnt_nxt     = cnt_r + 6'd1;
    neg_nxt     = neg_r;
    num_nxt     = num_r;
    trem_nxt    = trem_r;
    tq_nxt      = tq_r;
    noise_nxt   = noise_r;
    d_nxt       = d_r;
    dmag_nxt    = dmag_r;
    fw2_nxt     = fw2_r;
    d2_nxt      = d2_r;
    den_nxt     = den_r;
    lrem_nxt    = lrem_r;
    trans_nxt   = trans_r;
    prod_nxt    = prod_r;
    ov_nxt      = ov_r && !out_ready;
    adc_nxt     = adc_r;
    odet_nxt    = odet_r;
    otemp_nxt   = otemp_r;
    cross_nxt   = cross_r;
    clip_nxt    = clip_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt   = '0;
        neg_nxt   = diff[DET_W-1];
        num_nxt   = {1'b0, (diff[DET_W-1] ? TEMP_W'(-diff) : TEMP_W'(diff)), 8'h00}
                    + TNUM_W'(tau >> 1);
        trem_nxt  = '0;
        tq_nxt    = '0;
        noise_nxt = q_item.noise;
        if (q_valid && unarmed_r) begin
          last_nxt    = (resonance != '0) ? SG_NEG : SG_ZERO;
          unarmed_nxt = 1'b0;
        end
      end
      ST_TDIV: begin
        trem_nxt = tge ? (CODE_W+1)'(trem_sh - {2'b00, tau}) : (CODE_W+1)'(trem_sh);
        tq_nxt   = {tq_r[TQ_W-2:0], tge};
        num_nxt  = num_r << 1;
      end
      ST_UPD: temp_nxt = temp_sum[TEMP_W-1:0];
      ST_DET: d_nxt = $signed({1'b0, temp_r}) - $signed({1'b0, resonance, 12'h000});
      ST_SQR: begin
        dmag_nxt = dmag_abs;
        fw2_nxt  = linewidth * linewidth;
      end
      ST_DEN: begin
        d2_nxt    = dmag_r * dmag_r;
        cnt_nxt   = '0;
        trans_nxt = '0;
        lrem_nxt  = LREM_W'({fw2_r, 24'h000000});
        den_nxt   = LREM_W'({fw2_r, 24'h000000});
      end
      ST_LDIV: begin
        // The first step completes the denominator with the squared detuning.
        if (cnt_r == '0) begin
          den_nxt = den_r + LREM_W'({d2_r, 2'b00});
        end else begin
          trans_nxt = {trans_r[TRANS_W-2:0], lge};
          lrem_nxt  = (lge ? (lrem_r - den_r) : lrem_r) << 1;
        end
      end
      ST_ADCM: prod_nxt = peak * trans_r;
      ST_FIN: begin
        if (fin_go) begin
          ov_nxt    = 1'b1;
          clip_nxt  = 1'b0;
          odet_nxt  = d_r;
          otemp_nxt = temp_r;
          cross_nxt = (s_now != SG_ZERO) && (last_r != SG_ZERO) && (s_now != last_r);
          if (s_now != SG_ZERO) last_nxt = s_now;
          if (v <= 0) begin
            adc_nxt = '0;
          end else if (v >= top_lim) begin
            adc_nxt  = adc_top;
            clip_nxt = 1'b1;
          end else begin
            adc_nxt = CODE_W'((v + 38'sh80000) >>> 20);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      temp_r    <= '0;
      last_r    <= SG_ZERO;
      unarmed_r <= 1'b1;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      temp_r    <= temp_nxt;
      last_r    <= last_nxt;
      unarmed_r <= unarmed_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    num_r   <= num_nxt;
    trem_r  <= trem_nxt;
    tq_r    <= tq_nxt;
    noise_r <= noise_nxt;
    d_r     <= d_nxt;
    dmag_r  <= dmag_nxt;
    fw2_r   <= fw2_nxt;
    d2_r    <= d2_nxt;
    den_r   <= den_nxt;
    lrem_r  <= lrem_nxt;
    trans_r <= trans_nxt;
    prod_r  <= prod_nxt;
    adc_r   <= adc_nxt;
    odet_r  <= odet_nxt;
    otemp_r <= otemp_nxt;
    cross_r <= cross_nxt;
    clip_r  <= clip_nxt;
  end

endmodule

/* hw/rtl/microring_thermal_adc_plant_top.sv */
// An accepted input beat passes the front stage, the queue and the back sequencer
// before its result beat is offered; with the laser off the back skips the
// Lorentzian divider. The back takes one item at a time and so sets the
// throughput: it runs a 37-step thermal divider and the Lorentzian divider in
// turn. A held result stalls the back; the queue then fills.
// Reset (rst_n low, synchronous): config defaults, cold thermal state, latch rearmed.
// ----------------------------------------------------------------------------
// microring_thermal_adc_plant_top: microring thermal plant with ADC
// Configuration registers, a front stage, an item queue and the back
// sequencer that steps the thermal lag and models the photodiode reading.
// ----------------------------------------------------------------------------
module microring_thermal_adc_plant_top
  import mtap_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CODE_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DAC_BITS-1:0]      in_heater_code,
  input  logic signed [CODE_W-1:0] in_noise_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CODE_W-1:0]        out_adc_sample,
  output logic signed [DET_W-1:0]  out_detuning,
  output logic [TEMP_W-1:0]        out_temperature,
  output logic                     out_crossed,
  output logic                     out_clipped
);

  // Configuration registers. Writes must be made only while the block is idle;
  // the block does not enforce this. The datapath reads them live. Out-of-range
  // writes clamp to the floor values of linewidth, time constant and ADC top.
  logic [CODE_W-1:0] res_r, lw_r, tau_r, peak_r, top_r;
  logic              nen_r, len_r;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r  <= 16'd32768;
      lw_r   <= 16'd8192;
      tau_r  <= 16'd1024;
      peak_r <= 16'd48000;
      nen_r  <= 1'b0;
      len_r  <= 1'b1;
      top_r  <= 16'd4095;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_RESONANCE: res_r  <= cfg_data;
        REG_LINEWIDTH: lw_r   <= (cfg_data < 16'd16) ? 16'd16 : cfg_data;
        REG_TAU:       tau_r  <= (cfg_data < 16'd256) ? 16'd256 : cfg_data;
        REG_PEAK:      peak_r <= cfg_data;
        REG_NOISE_EN:  nen_r  <= cfg_data[0];
        REG_LASER_EN:  len_r  <= cfg_data[0];
        REG_ADC_TOP:   top_r  <= (cfg_data == '0) ? 16'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  // Front stage to queue.
  logic  push_valid, push_ready;
  item_t push_item;

  mtap_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_heater_code  (in_heater_code),
    .in_noise_sample (in_noise_sample),
    .noise_en        (nen_r),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  // The queue lets the front keep taking beats while the back is busy.
  logic  q_valid, q_pop;
  item_t q_item;

  mtap_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  // The back sequencer owns the thermal state and the crossing latch and
  // holds each result in its output register until the beat is taken.
  mtap_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .resonance       (res_r),
    .linewidth       (lw_r),
    .tau             (tau_r),
    .peak            (peak_r),
    .laser_en        (len_r),
    .adc_top         (top_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_adc_sample  (out_adc_sample),
    .out_detuning    (out_detuning),
    .out_temperature (out_temperature),
    .out_crossed     (out_crossed),
    .out_clipped     (out_clipped)
  );

endmodule

/* hw/rtl/mtap_checker.sv */
// ----------------------------------------------------------------------------
// mtap_checker: port-level checks
// Watches the top-level ports of the plant over time.
// ----------------------------------------------------------------------------
module mtap_checker
  import mtap_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [CODE_W-1:0]        out_adc_sample,
  input logic signed [DET_W-1:0]  out_detuning,
  input logic [TEMP_W-1:0]        out_temperature,
  input logic                     out_crossed,
  input logic                     out_clipped
);

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // The temperature never exceeds the largest heater target.
  a_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature <= 28'hFFF0000)
    else $error("temperature beyond heater range");

  // A crossing needs a nonzero detuning.
  a_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crossed |-> out_detuning != '0)
    else $error("crossing reported at zero detuning");

  // A clipped sample is the top code, which is never zero.
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_adc_sample != '0)
    else $error("clipped sample reads zero");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind microring_thermal_adc_plant_top mtap_checker u_mtap_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_adc_sample  (out_adc_sample),
  .out_detuning    (out_detuning),
  .out_temperature (out_temperature),
  .out_crossed     (out_crossed),
  .out_clipped     (out_clipped)
);

/* verif/tb_microring_thermal_adc_plant_top.sv */
// ----------------------------------------------------------------------------
// tb_microring_thermal_adc_plant_top: self-checking bench for the ring plant
// A directed table of beats and register writes is followed by random phases
// under random settings. An in-bench model of the thermal lag, the Lorentzian
// and the ADC predicts each result beat not typed in by hand; all are checked in order.
// ----------------------------------------------------------------------------
module tb_microring_thermal_adc_plant_top;
  import mtap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES = 17;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [CODE_W-1:0]       adc;
    logic signed [DET_W-1:0] det;
    logic [TEMP_W-1:0]       temp;
    logic                    crossed;
    logic                    clipped;
  } reading_t;

  // One row of the directed table: either a register write or an input beat.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CODE_W-1:0]    val;
    logic [DAC_BITS-1:0]  code;
    logic [CODE_W-1:0]    nz;
    logic                 typed;
    reading_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DAC_BITS-1:0] in_heater_code = '0;
  logic signed [CODE_W-1:0] in_noise_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_W-1:0] out_adc_sample;
  logic signed [DET_W-1:0] out_detuning;
  logic [TEMP_W-1:0] out_temperature;
  logic out_crossed;
  logic out_clipped;

  microring_thermal_adc_plant_top dut (.*);

  always #5 clk = ~clk;

  // Shadow of the register file and of the plant state.
  bit [15:0] shadow_res, lw_code, tau_code, peak_code, top_code;
  bit nz_en, laser_en;
  longint temp_state;
  int last_sgn;
  bit unarmed;

  reading_t pending[$];
  int errors = 0;
  int results_seen = 0;
  int crossings_seen = 0;
  int clips_seen = 0;
  int beats_sent = 0;
  longint cycles = 0;

  // Receiver controls, set by the stimulus process.
  int hold_cycles = 0;
  bit no_idle = 1'b0;

  // Uniform random integer in lo..hi.
  function automatic int rand_between(int lo, int hi);
    int unsigned span;
    span = int'(hi - lo + 1);
    return lo + int'($urandom % span);
  endfunction

  function automatic void shadow_reset();
    shadow_res = 16'd32768; lw_code = 16'd8192; tau_code = 16'd1024;
    peak_code = 16'd48000; top_code = 16'd4095; nz_en = 1'b0; laser_en = 1'b1;
    temp_state = 0; last_sgn = 0; unarmed = 1'b1;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    case (idx)
      REG_RESONANCE: shadow_res = v;
      REG_LINEWIDTH: lw_code = (v < 16) ? 16'd16 : v;
      REG_TAU:       tau_code = (v < 256) ? 16'd256 : v;
      REG_PEAK:      peak_code = v;
      REG_NOISE_EN:  nz_en = v[0];
      REG_LASER_EN:  laser_en = v[0];
      REG_ADC_TOP:   top_code = (v == 0) ? 16'd1 : v;
      default: ;
    endcase
  endfunction

  // Advances the plant by one heater beat and returns the reading it yields.
  function automatic reading_t plant_step(logic [DAC_BITS-1:0] code,
                                          logic signed [CODE_W-1:0] nz);
    longint target, diff, delta, res, d, v, top_lim, n;
    longint unsigned mag, fw, fw2, num, den, q, rem;
    int s;
    reading_t r;
    n = nz_en ? longint'(nz) : 0;
    res = longint'(shadow_res) << (TEMP_FRAC_BITS - 4);
    if (unarmed) begin
      last_sgn = (res > 0) ? -1 : 0;
      unarmed = 1'b0;
    end
    // First-order lag, rounded half away from zero.
    target = longint'(code) << TEMP_FRAC_BITS;
    diff = target - temp_state;
    mag = (diff < 0) ? -diff : diff;
    mag = (mag * 256 + tau_code / 2) / tau_code;
    delta = (diff < 0) ? -longint'(mag) : longint'(mag);
    temp_state = temp_state + delta;
    d = temp_state - res;
    q = 0;
    if (laser_en) begin
      fw = longint'(lw_code) << (TEMP_FRAC_BITS - 4);
      fw2 = fw * fw;
      mag = (d < 0) ? -d : d;
      num = fw2;
      den = fw2 + 4 * mag * mag;
      rem = num;
      for (int k = 0; k < 17; k++) begin
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q | 1;
        end
        rem = rem << 1;
      end
    end
    v = longint'(peak_code) * longint'(q) + n * 65536;
    top_lim = longint'(top_code) * (longint'(1) << 20) + (longint'(1) << 19);
    r.clipped = 1'b0;
    if (v <= 0) r.adc = '0;
    else if (v >= top_lim) begin
      r.adc = top_code;
      r.clipped = 1'b1;
    end else r.adc = 16'((v + (longint'(1) << 19)) >>> 20);
    s = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    r.crossed = (s != 0 && last_sgn != 0 && s != last_sgn);
    if (s != 0) last_sgn = s;
    r.det = d[DET_W-1:0];
    r.temp = temp_state[TEMP_W-1:0];
    return r;
  endfunction

  // Waits until every expected beat has arrived and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random idle before a beat: mostly none or short, now and then long.
  task automatic sender_gap();
    int g, pick;
    pick = rand_between(0, 99);
    if (no_idle || pick < 65) g = 0;
    else if (pick < 95) g = rand_between(1, 4);
    else g = rand_between(20, 90);
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Offers one heater beat; valid stays high afterwards until lowered by a gap or a drain.
  task automatic send_heater(logic [DAC_BITS-1:0] code, logic [CODE_W-1:0] nz,
                             bit typed, reading_t want);
    reading_t pr;
    @(negedge clk);
    in_valid <= 1'b1;
    in_heater_code <= code;
    in_noise_sample <= nz;
    do @(posedge clk); while (!in_ready);
    pr = plant_step(code, nz);
    pending.push_back(typed ? want : pr);
    beats_sent++;
  endtask

  function automatic logic [15:0] pick_value(int lo, int hi);
    if (rand_between(0, 3) == 0) return (rand_between(0, 1) != 0) ? 16'(hi) : 16'(lo);
    return 16'(rand_between(lo, hi));
  endfunction

  // The directed table. The first beat after reset is typed in by hand: a cold
  // plant sitting far below the default resonance gives a dim reading of 46.
  row_t table_rows[] = '{
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h0000, 1'b1,
      '{16'd46, -29'sd134217728, 28'd0, 1'b0, 1'b0}},
    '{1'b0, 3'd0, 16'd0, 12'd4095, 16'h7FFF, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd4095, 16'h8000, 1'b0, '0},
    '{1'b1, REG_NOISE_EN, 16'd1, 12'd0, 16'h0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h7FFF, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h8000, 1'b0, '0},
    '{1'b1, REG_LASER_EN, 16'd0, 12'd0, 16'h0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd100,  16'h0018, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd100,  16'h0008, 1'b0, '0},
    '{1'b1, REG_ADC_TOP, 16'd0, 12'd0, 16'h0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h0018, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h0017, 1'b0, '0},
    '{1'b1, REG_TAU, 16'd0, 12'd0, 16'h0, 1'b0, '0},
    '{1'b1, REG_RESONANCE, 16'd32768, 12'd0, 16'h0, 1'b0, '0},
    '{1'b1, REG_LASER_EN, 16'd1, 12'd0, 16'h0, 1'b0, '0},
    '{1'b1, REG_NOISE_EN, 16'd0, 12'd0, 16'h0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h0000, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd2048, 16'h0000, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd4095, 16'h0000, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd2048, 16'h0000, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h0000, 1'b0, '0},
    '{1'b1, REG_LINEWIDTH, 16'd0, 12'd0, 16'h0, 1'b0, '0},
    '{1'b1, REG_PEAK, 16'd65535, 12'd0, 16'h0, 1'b0, '0},
    '{1'b1, REG_ADC_TOP, 16'd65535, 12'd0, 16'h0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd2048, 16'h0000, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd2049, 16'h0000, 1'b0, '0},
    '{1'b1, REG_UNUSED, 16'd1234, 12'd0, 16'h0, 1'b0, '0},
    '{1'b1, REG_RESONANCE, 16'd0, 12'd0, 16'h0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd0,    16'h0000, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 12'd4095, 16'h0000, 1'b0, '0}
  };

  // Stimulus: directed table, then random phases, then the final verdict.
  initial begin
    logic [DAC_BITS-1:0] code;
    logic [CODE_W-1:0] nz;
    int center;
    shadow_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain();
        write_reg(table_rows[i].idx, table_rows[i].val);
      end else begin
        send_heater(table_rows[i].code, table_rows[i].nz, table_rows[i].typed,
                    table_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // New settings are written only once the plant is idle.
      drain();
      no_idle = (ph % 5 == 4);
      for (int r = 0; r < 7; r++) begin
        if (ph == 0 || rand_between(0, 1) != 0) begin
          case (r)
            0: write_reg(REG_RESONANCE, pick_value(0, 65535));
            1: write_reg(REG_LINEWIDTH, pick_value(0, 65535));
            2: write_reg(REG_TAU, (rand_between(0, 1) != 0) ?
                         16'(rand_between(0, 2048)) : pick_value(0, 65535));
            3: write_reg(REG_PEAK, pick_value(0, 65535));
            4: write_reg(REG_NOISE_EN, 16'(rand_between(0, 1)));
            5: write_reg(REG_LASER_EN, 16'(rand_between(0, 3) != 0));
            default: write_reg(REG_ADC_TOP, pick_value(0, 65535));
          endcase
        end
      end
      // In one phase the receiver stalls for a long stretch while beats keep
      // coming, so the queue fills and the input side backs up.
      if (ph == 3) hold_cycles = 600;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sender_gap();
        center = shadow_res >> 4;
        if (rand_between(0, 2) == 0) begin
          // Hover around resonance so the crossing latch gets exercised.
          center = center + rand_between(0, 16) - 8;
          if (center < 0) center = 0;
          if (center > 4095) center = 4095;
          code = 12'(center);
        end else begin
          code = 12'(rand_between(0, 4095));
        end
        nz = (rand_between(0, 1) != 0) ? 16'(rand_between(0, 65535)) :
             16'(rand_between(0, 64) - 32);
        send_heater(code, nz, 1'b0, '0);
      end
    end

    drain();
    $display("Sent %0d beats; %0d results checked, %0d crossings, %0d clipped readings.",
             beats_sent, results_seen, crossings_seen, clips_seen);
    $display("Covered defaults, register extremes, laser off, noise gating and a long stall.");
    if (errors == 0) begin
      $display("PASS microring_thermal_adc_plant_top");
    end else begin
      $display("FAIL microring_thermal_adc_plant_top");
    end
    $finish;
  end

  // Receiver: random stalls, plus the long hold-off requested by the stimulus.
  initial begin
    int stall;
    int pick;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        pick = rand_between(0, 99);
        if (pick < 70) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall = (pick < 96) ? rand_between(0, 3) : rand_between(20, 80);
        end
      end
    end
  end

  // Checker: every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected (adc %0d)", $time, out_adc_sample);
      end else begin
        exp_r = pending.pop_front();
        results_seen++;
        if (out_crossed) crossings_seen++;
        if (out_clipped) clips_seen++;
        if (out_adc_sample !== exp_r.adc) begin
          errors++;
          $display("%0t: adc_sample expected %0d got %0d", $time, exp_r.adc, out_adc_sample);
        end
        if (out_detuning !== exp_r.det) begin
          errors++;
          $display("%0t: detuning expected %0d got %0d", $time, exp_r.det, out_detuning);
        end
        if (out_temperature !== exp_r.temp) begin
          errors++;
          $display("%0t: temperature expected %0d got %0d", $time, exp_r.temp,
                   out_temperature);
        end
        if (out_crossed !== exp_r.crossed) begin
          errors++;
          $display("%0t: crossed expected %0b got %0b", $time, exp_r.crossed, out_crossed);
        end
        if (out_clipped !== exp_r.clipped) begin
          errors++;
          $display("%0t: clipped expected %0b got %0b", $time, exp_r.clipped, out_clipped);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending.size());
      $display("FAIL microring_thermal_adc_plant_top");
      $finish;
    end
  end

endmodule
